FILE: hdl/lsm_pkg.sv
// Shared constants for the layer stack manager: opcodes, status codes, stream widths.
package lsm_pkg;

    // Default number of layers
    localparam int DEF_MAX_LAYERS = 256;

    // Item field widths
    localparam int OPCODE_W   = 2;
    localparam int LAYER_ID_W = 8;
    localparam int REQ_H_W    = 10;
    localparam int STATUS_W   = 2;
    localparam int RES_LYR_W  = 8;
    localparam int RES_H_W    = 9;
    localparam int TOP_H_W    = 9;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SET_H = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;
    localparam logic [STATUS_W-1:0] ST_H_EMPTY   = 2'd3;

endpackage

FILE: hdl/lsm_ram.sv
// Simple dual-port synchronous RAM with registered read.
module lsm_ram import lsm_pkg::*; #(
    parameter int DEPTH = DEF_MAX_LAYERS,
    parameter int WIDTH = 8,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_q [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_q[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_q[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/lsm_ctrl.sv
// Sequencer: decodes items, scans, shifts the order stack and builds results.
module lsm_ctrl import lsm_pkg::*; #(
    parameter int MAX_LAYERS = DEF_MAX_LAYERS,
    localparam int ID_W = $clog2(MAX_LAYERS),
    localparam int H_W  = ID_W + 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    // layer table: {in_use, height}
    output logic                 a_we,
    output logic [ID_W-1:0]      a_waddr,
    output logic [H_W:0]         a_wdata,
    output logic [ID_W-1:0]      a_raddr,
    input  logic [H_W:0]         a_rdata,
    // order stack: layer at each height
    output logic                 b_we,
    output logic [ID_W-1:0]      b_waddr,
    output logic [ID_W-1:0]      b_wdata,
    output logic [ID_W-1:0]      b_raddr,
    input  logic [ID_W-1:0]      b_rdata
);

    localparam int C_W = (ID_W + 2 > REQ_H_W + 1) ? ID_W + 2 : REQ_H_W + 1;
    localparam int N_W = ID_W + 1;
    localparam logic [ID_W-1:0]       LAST_IDX = ID_W'(MAX_LAYERS - 1);
    localparam logic [N_W-1:0]        NUM_LYR  = N_W'(MAX_LAYERS);
    localparam logic signed [C_W-1:0] NEG1     = '1;
    localparam logic signed [C_W-1:0] ONE      = C_W'(1);

    // Sequencer states
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_LOOKUP = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_MOVE   = 3'd5;
    localparam logic [2:0] S_FINAL  = 3'd6;
    localparam logic [2:0] S_RESP   = 3'd7;

    // Control registers
    logic [2:0]             state_reg, state_next;
    logic signed [H_W-1:0]  top_reg, top_next;
    logic [ID_W-1:0]        clr_reg, clr_next;
    logic [N_W-1:0]         scan_cnt_reg, scan_cnt_next;
    logic                   scan_vld_reg, scan_vld_next;
    logic                   pend_vld_reg, pend_vld_next;
    logic                   m_valid_reg, m_valid_next;

    // Payload registers
    logic [OPCODE_W-1:0]    op_reg, op_next;
    logic [LAYER_ID_W-1:0]  id_reg, id_next;
    logic signed [REQ_H_W-1:0] rh_reg, rh_next;
    logic [ID_W-1:0]        chk_reg, chk_next;
    logic signed [H_W-1:0]  tgt_h_reg, tgt_h_next;
    logic                   keep_reg, keep_next;
    logic                   dn_reg, dn_next;
    logic                   grow_reg, grow_next;
    logic                   shrink_reg, shrink_next;
    logic [N_W-1:0]         cnt_reg, cnt_next;
    logic [ID_W-1:0]        src_reg, src_next;
    logic [ID_W-1:0]        pend_dst_reg, pend_dst_next;
    logic [STATUS_W-1:0]    res_st_reg, res_st_next;
    logic [RES_LYR_W-1:0]   res_lyr_reg, res_lyr_next;
    logic signed [RES_H_W-1:0] res_h_reg, res_h_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;

    // Decode helpers
    logic [ID_W-1:0]        id_idx;
    logic                   id_ok;
    logic signed [C_W-1:0]  rq, rq_eff, top_c, old_c, h1, lim, hc;
    logic signed [H_W-1:0]  old_h;
    logic                   rd_ok;

    // Move plan
    logic                   mv_dn, mv_grow, mv_shrink;
    logic signed [C_W-1:0]  mv_start, mv_n;

    assign id_idx = ID_W'(id_reg);
    assign id_ok  = 32'(id_reg) < 32'(MAX_LAYERS);
    assign rq     = C_W'(rh_reg);
    assign rq_eff = (op_reg == OP_FREE) ? NEG1 : rq;
    assign top_c  = C_W'(top_reg);
    assign old_h  = a_rdata[H_W-1:0];
    assign old_c  = C_W'(old_h);
    assign rd_ok  = (rq >= 0) && (rq <= top_c);

    // Clamp the requested height: hidden floor, stack top ceiling (one above the top for a hidden layer)
    assign h1  = (rq_eff < NEG1) ? NEG1 : rq_eff;
    assign lim = (old_c >= 0) ? top_c : top_c + ONE;
    assign hc  = (h1 > lim) ? lim : h1;

    // Which way the layers in between shift, where it starts, how far
    always_comb begin
        mv_dn     = 1'b0;
        mv_grow   = 1'b0;
        mv_shrink = 1'b0;
        mv_start  = old_c;
        mv_n      = '0;
        priority if (old_c > hc && hc >= 0) begin
            mv_dn = 1'b1;
            mv_n  = old_c - hc;
        end else if (old_c > hc) begin
            mv_shrink = 1'b1;
            mv_n      = top_c - old_c;
        end else if (old_c < hc && old_c >= 0) begin
            mv_n = hc - old_c;
        end else if (old_c < hc) begin
            mv_dn    = 1'b1;
            mv_grow  = 1'b1;
            mv_start = top_c + ONE;
            mv_n     = top_c + ONE - hc;
        end else begin
            mv_n = '0;
        end
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        top_next      = top_reg;
        clr_next      = clr_reg;
        scan_cnt_next = scan_cnt_reg;
        scan_vld_next = scan_vld_reg;
        pend_vld_next = pend_vld_reg;
        m_valid_next  = m_valid_reg;
        op_next       = op_reg;
        id_next       = id_reg;
        rh_next       = rh_reg;
        chk_next      = chk_reg;
        tgt_h_next    = tgt_h_reg;
        keep_next     = keep_reg;
        dn_next       = dn_reg;
        grow_next     = grow_reg;
        shrink_next   = shrink_reg;
        cnt_next      = cnt_reg;
        src_next      = src_reg;
        pend_dst_next = pend_dst_reg;
        res_st_next   = res_st_reg;
        res_lyr_next  = res_lyr_reg;
        res_h_next    = res_h_reg;
        m_data_next   = m_data_reg;
        s_tready      = 1'b0;
        a_we          = 1'b0;
        a_waddr       = '0;
        a_wdata       = '0;
        a_raddr       = '0;
        b_we          = 1'b0;
        b_waddr       = '0;
        b_wdata       = '0;
        b_raddr       = '0;

        // result register drains independently
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            // sweep the layer table to mark every layer free
            S_CLEAR: begin
                a_we     = 1'b1;
                a_waddr  = clr_reg;
                a_wdata  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next = s_tdata[OPCODE_W-1:0];
                    id_next = s_tdata[OPCODE_W +: LAYER_ID_W];
                    rh_next = s_tdata[OPCODE_W + LAYER_ID_W +: REQ_H_W];
                    if (s_tdata[OPCODE_W-1:0] == OP_ALLOC) begin
                        scan_cnt_next = '0;
                        scan_vld_next = 1'b0;
                        state_next    = S_SCAN;
                    end else begin
                        state_next = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP: begin
                a_raddr    = id_idx;
                b_raddr    = rq[ID_W-1:0];
                state_next = S_EVAL;
            end
            S_EVAL: begin
                unique case (op_reg)
                    OP_READ: begin
                        if (rd_ok) begin
                            res_st_next  = ST_OK;
                            res_lyr_next = RES_LYR_W'(b_rdata);
                            res_h_next   = RES_H_W'(rh_reg);
                        end else begin
                            res_st_next  = ST_H_EMPTY;
                            res_lyr_next = '0;
                            res_h_next   = '1;
                        end
                        state_next = S_RESP;
                    end
                    OP_SET_H, OP_FREE: begin
                        if (!id_ok || !a_rdata[H_W]) begin
                            res_st_next  = ST_NOT_ALLOC;
                            res_lyr_next = id_reg;
                            res_h_next   = '1;
                            state_next   = S_RESP;
                        end else begin
                            tgt_h_next    = H_W'(hc);
                            keep_next     = (op_reg == OP_SET_H);
                            dn_next       = mv_dn;
                            grow_next     = mv_grow;
                            shrink_next   = mv_shrink;
                            cnt_next      = N_W'(mv_n);
                            src_next      = mv_dn ? ID_W'(mv_start - ONE)
                                                  : ID_W'(mv_start + ONE);
                            pend_vld_next = 1'b0;
                            state_next    = S_MOVE;
                        end
                    end
                    OP_ALLOC: begin
                        state_next = S_RESP;
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end
            // find the lowest free layer, one table read per cycle
            S_SCAN: begin
                if (scan_cnt_reg < NUM_LYR) begin
                    a_raddr       = scan_cnt_reg[ID_W-1:0];
                    chk_next      = scan_cnt_reg[ID_W-1:0];
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                    scan_vld_next = 1'b1;
                end else begin
                    scan_vld_next = 1'b0;
                end
                if (scan_vld_reg) begin
                    if (!a_rdata[H_W]) begin
                        a_we         = 1'b1;
                        a_waddr      = chk_reg;
                        a_wdata      = {1'b1, {H_W{1'b1}}};
                        res_st_next  = ST_OK;
                        res_lyr_next = RES_LYR_W'(chk_reg);
                        res_h_next   = '1;
                        state_next   = S_RESP;
                    end else if (chk_reg == LAST_IDX) begin
                        res_st_next  = ST_NO_FREE;
                        res_lyr_next = '0;
                        res_h_next   = '1;
                        state_next   = S_RESP;
                    end
                end
            end
            // shift stack entries one a cycle; each write follows its read through the pending register
            S_MOVE: begin
                if (pend_vld_reg) begin
                    b_we    = 1'b1;
                    b_waddr = pend_dst_reg;
                    b_wdata = b_rdata;
                    a_we    = 1'b1;
                    a_waddr = b_rdata;
                    a_wdata = {1'b1, 1'b0, pend_dst_reg};
                end
                if (cnt_reg != '0) begin
                    b_raddr       = src_reg;
                    pend_vld_next = 1'b1;
                    pend_dst_next = dn_reg ? src_reg + 1'b1 : src_reg - 1'b1;
                    src_next      = dn_reg ? src_reg - 1'b1 : src_reg + 1'b1;
                    cnt_next      = cnt_reg - 1'b1;
                end else begin
                    pend_vld_next = 1'b0;
                    if (!pend_vld_reg) begin
                        state_next = S_FINAL;
                    end
                end
            end
            // place the addressed layer and adjust the stack top
            S_FINAL: begin
                a_we    = 1'b1;
                a_waddr = id_idx;
                a_wdata = {keep_reg, tgt_h_reg};
                if (tgt_h_reg >= 0) begin
                    b_we    = 1'b1;
                    b_waddr = tgt_h_reg[ID_W-1:0];
                    b_wdata = id_idx;
                end
                if (grow_reg) begin
                    top_next = top_reg + 1'b1;
                end else if (shrink_reg) begin
                    top_next = top_reg - 1'b1;
                end
                res_st_next  = ST_OK;
                res_lyr_next = id_reg;
                res_h_next   = keep_reg ? RES_H_W'(tgt_h_reg) : '1;
                state_next   = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{(M_TDATA_W - STATUS_W - RES_LYR_W - RES_H_W
                                      - TOP_H_W){1'b0}},
                                    TOP_H_W'(top_reg), res_h_reg, res_lyr_reg, res_st_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            top_reg      <= '1;
            clr_reg      <= '0;
            scan_cnt_reg <= '0;
            scan_vld_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            top_reg      <= top_next;
            clr_reg      <= clr_next;
            scan_cnt_reg <= scan_cnt_next;
            scan_vld_reg <= scan_vld_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        rh_reg       <= rh_next;
        chk_reg      <= chk_next;
        tgt_h_reg    <= tgt_h_next;
        keep_reg     <= keep_next;
        dn_reg       <= dn_next;
        grow_reg     <= grow_next;
        shrink_reg   <= shrink_next;
        cnt_reg      <= cnt_next;
        src_reg      <= src_next;
        pend_dst_reg <= pend_dst_next;
        res_st_reg   <= res_st_next;
        res_lyr_reg  <= res_lyr_next;
        res_h_reg    <= res_h_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: hdl/layer_stack_manager.sv
// Top level of the layer stack manager: sequencer plus layer table and order stack RAMs.
//
//  channel   dir  tdata fields (lowest bit up)
//  s_axis    in   opcode[1:0], layer_id[9:2], req_height[19:10]
//  m_axis    out  status[1:0], result_layer[9:2], result_height[18:10], top_height[27:19]
//
// Item steps: read looks up the order stack and answers; set height or free looks up
// the layer, shifts the layers in between on the order stack (up to MAX_LAYERS - 1)
// and places it; allocate scans the layer table upward to the lowest free layer.
// The shift loop on the order stack RAM sets the worst case: one entry a cycle.
// After reset a clearing pass runs over every entry of the layer table;
// s_tready stays low until it is done.
// A finished item sits in the output register while the next one is taken.
module layer_stack_manager import lsm_pkg::*; #(
    parameter int MAX_LAYERS = DEF_MAX_LAYERS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // opcode, layer_id, req_height
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // status, result_layer, result_height, top_height
);

    localparam int ID_W = $clog2(MAX_LAYERS);
    localparam int H_W  = ID_W + 1;

    logic            a_we;
    logic [ID_W-1:0] a_waddr, a_raddr;
    logic [H_W:0]    a_wdata, a_rdata;
    logic            b_we;
    logic [ID_W-1:0] b_waddr, b_raddr, b_wdata, b_rdata;

    // Sequencer
    lsm_ctrl #(.MAX_LAYERS(MAX_LAYERS)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .a_we     (a_we),
        .a_waddr  (a_waddr),
        .a_wdata  (a_wdata),
        .a_raddr  (a_raddr),
        .a_rdata  (a_rdata),
        .b_we     (b_we),
        .b_waddr  (b_waddr),
        .b_wdata  (b_wdata),
        .b_raddr  (b_raddr),
        .b_rdata  (b_rdata)
    );

    // Layer table: in_use flag and height per layer
    lsm_ram #(.DEPTH(MAX_LAYERS), .WIDTH(H_W + 1)) u_layer_tbl (
        .aclk    (aclk),
        .wr_en   (a_we),
        .wr_addr (a_waddr),
        .wr_data (a_wdata),
        .rd_addr (a_raddr),
        .rd_data (a_rdata)
    );

    // Order stack: layer id at each height
    lsm_ram #(.DEPTH(MAX_LAYERS), .WIDTH(ID_W)) u_order_stk (
        .aclk    (aclk),
        .wr_en   (b_we),
        .wr_addr (b_waddr),
        .wr_data (b_wdata),
        .rd_addr (b_raddr),
        .rd_data (b_rdata)
    );

endmodule

FILE: hdl/lsm_checker.sv
// Port-level assertions for the layer stack manager, bound to the top level.
module lsm_checker import lsm_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [STATUS_W-1:0]  st;
    logic [RES_LYR_W-1:0] lyr;
    logic [RES_H_W-1:0]   rhgt;

    assign st   = m_tdata[STATUS_W-1:0];
    assign lyr  = m_tdata[STATUS_W +: RES_LYR_W];
    assign rhgt = m_tdata[STATUS_W + RES_LYR_W +: RES_H_W];

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset starts the clearing pass with no result pending
    a_reset_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("block ready right after reset");

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // any failure reports a hidden height
    a_fail_hidden: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st != ST_OK |-> rhgt == '1)
        else $error("failed item reports a height");

    // no free layer and empty height report layer zero
    a_fail_layer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == ST_NO_FREE || st == ST_H_EMPTY) |-> lyr == '0)
        else $error("failed lookup reports a layer");

endmodule

bind layer_stack_manager lsm_checker u_lsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
